// ===== sv/diffusion_stencil_step_core_assert.svh =====
// Assertion helpers for the checker file of this block.
`ifndef DIFFUSION_STENCIL_STEP_CORE_ASSERT_SVH
`define DIFFUSION_STENCIL_STEP_CORE_ASSERT_SVH

// Checked only outside reset.
`define DSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define DSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/dss_pkg.sv =====
`timescale 1ns / 1ps
package dss_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MIN_POINTS = 3;
  localparam int PT_W       = $clog2(MAX_POINTS);

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 6;
  localparam int DATA_W = 32;
  localparam int GP_W   = 7;
  localparam int Q24_W  = 24;
  localparam int FRAC_W = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLING    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 2'd3;

  localparam logic [GP_W-1:0]  RST_GRID_POINTS = 7'd64;
  localparam logic [Q24_W-1:0] RST_COUPLING    = 24'd8388608;
  localparam logic [Q24_W-1:0] RST_SOURCE_STEP = 24'd16384;
  localparam logic [Q24_W-1:0] RST_TOLERANCE   = 24'd17;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STATUS  = 2'd3;

  // Datapath widths: laplacian, its split halves, partial products, full product
  localparam int LAP_W  = DATA_W + 2;
  localparam int LO_W   = 17;
  localparam int HI_W   = LAP_W - LO_W;
  localparam int PPL_W  = LO_W + Q24_W;
  localparam int PPH_W  = HI_W + Q24_W + 1;
  localparam int PROD_W = LAP_W + Q24_W + 1;
  localparam int TERM_W = PROD_W - FRAC_W;
  localparam int SAT_W  = 40;

  localparam logic signed [SAT_W-1:0] S32_MAX = 40'sh007FFFFFFF;
  localparam logic signed [SAT_W-1:0] S32_MIN = 40'shFF80000000;

  // Microprogram addresses
  localparam int UPC_W = 3;
  localparam logic [UPC_W-1:0] U_IDLE      = 3'd0;
  localparam logic [UPC_W-1:0] U_ADV_RUN   = 3'd1;
  localparam logic [UPC_W-1:0] U_ADV_DRAIN = 3'd2;
  localparam logic [UPC_W-1:0] U_ADV_TRIM  = 3'd3;
  localparam logic [UPC_W-1:0] U_CLEAR     = 3'd4;
  localparam logic [UPC_W-1:0] U_RESP      = 3'd5;
  localparam logic [UPC_W-1:0] U_LOAD      = 3'd6;

  typedef enum logic [2:0] {
    JMP_GOTO,
    JMP_DISPATCH,
    JMP_STAY_NOT_LAST,
    JMP_STAY_BUSY,
    JMP_STAY_BLOCKED
  } jmp_e;

  typedef struct packed {
    logic             in_ready;
    logic             init;
    logic             sweep_rd;
    logic             resp_rd;
    logic             out_load;
    logic             clr_all;
    logic             trim;
    jmp_e             jmp;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic cnt_last;
    logic pipe_busy;
    logic out_blocked;
  } stat_t;

  typedef struct packed {
    logic [GP_W-1:0]  grid_points;
    logic [Q24_W-1:0] coupling;
    logic [Q24_W-1:0] source_step;
    logic [Q24_W-1:0] tolerance;
  } cfg_t;

  // Control store
  function automatic ctrl_t ucode_rom(logic [UPC_W-1:0] addr);
    ctrl_t cw;
    cw = '0;
    cw.jmp = JMP_GOTO;
    cw.target = U_IDLE;
    case (addr)
      U_IDLE: begin
        cw.in_ready = 1'b1;
        cw.init     = 1'b1;
        cw.jmp      = JMP_DISPATCH;
      end
      U_ADV_RUN: begin
        cw.sweep_rd = 1'b1;
        cw.jmp      = JMP_STAY_NOT_LAST;
        cw.target   = U_ADV_DRAIN;
      end
      U_ADV_DRAIN: begin
        cw.jmp    = JMP_STAY_BUSY;
        cw.target = U_ADV_TRIM;
      end
      U_ADV_TRIM: begin
        cw.trim   = 1'b1;
        cw.target = U_RESP;
      end
      U_CLEAR: begin
        cw.clr_all = 1'b1;
        cw.target  = U_RESP;
      end
      U_RESP: begin
        cw.resp_rd = 1'b1;
        cw.target  = U_LOAD;
      end
      U_LOAD: begin
        cw.out_load = 1'b1;
        cw.jmp      = JMP_STAY_BLOCKED;
        cw.target   = U_IDLE;
      end
      default: begin
        cw.target = U_IDLE;
      end
    endcase
    return cw;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(logic signed [SAT_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX[DATA_W-1:0];
    end else if (v < S32_MIN) begin
      r = S32_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/dss_in_if.sv =====
`timescale 1ns / 1ps
interface dss_in_if;
  logic                       valid;
  logic                       ready;
  logic [dss_pkg::CMD_W-1:0]  cmd;
  logic [dss_pkg::IDX_W-1:0]  point_index;

  modport source (output valid, output cmd, output point_index, input ready);
  modport sink (input valid, input cmd, input point_index, output ready);
endinterface

// ===== sv/dss_out_if.sv =====
`timescale 1ns / 1ps
interface dss_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dss_pkg::DATA_W-1:0] point_value;
  logic signed [dss_pkg::DATA_W-1:0] mid_change;
  logic                              converged;

  modport source (output valid, output point_value, output mid_change, output converged,
                  input ready);
  modport sink (input valid, input point_value, input mid_change, input converged,
                output ready);
endinterface

// ===== sv/dss_ram.sv =====
`timescale 1ns / 1ps
module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dss_useq.sv =====
`timescale 1ns / 1ps
module dss_useq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [dss_pkg::CMD_W-1:0]    cmd_i,
  input  dss_pkg::stat_t               stat_i,
  output dss_pkg::ctrl_t               ctrl_o,
  output logic                         in_ready_o
);
  import dss_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d;
  ctrl_t            cw;

  assign cw         = ucode_rom(upc_q);
  assign ctrl_o     = cw;
  assign in_ready_o = cw.in_ready;

  always_comb begin
    upc_d = upc_q;
    case (cw.jmp)
      JMP_GOTO: upc_d = cw.target;
      JMP_DISPATCH: begin
        if (in_valid_i) begin
          case (cmd_i)
            CMD_ADVANCE: upc_d = U_ADV_RUN;
            CMD_CLEAR:   upc_d = U_CLEAR;
            default:     upc_d = U_RESP;
          endcase
        end
      end
      JMP_STAY_NOT_LAST: upc_d = stat_i.cnt_last ? cw.target : upc_q;
      JMP_STAY_BUSY:     upc_d = stat_i.pipe_busy ? upc_q : cw.target;
      JMP_STAY_BLOCKED:  upc_d = stat_i.out_blocked ? upc_q : cw.target;
      default:           upc_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ===== sv/dss_datapath.sv =====
`timescale 1ns / 1ps
module dss_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dss_pkg::cfg_t             cfg_i,
  input  dss_pkg::ctrl_t            ctrl_i,
  input  logic                      in_fire_i,
  input  logic [dss_pkg::CMD_W-1:0] cmd_i,
  input  logic [dss_pkg::IDX_W-1:0] idx_i,
  output dss_pkg::stat_t            stat_o,
  dss_out_if.source                 out_o
);
  import dss_pkg::*;

  // Grid size in use
  logic [GP_W-1:0] n_pts, n_m1, mid;

  always_comb begin
    n_pts = cfg_i.grid_points;
    if (n_pts < GP_W'(MIN_POINTS)) begin
      n_pts = GP_W'(MIN_POINTS);
    end else if (n_pts > GP_W'(MAX_POINTS)) begin
      n_pts = GP_W'(MAX_POINTS);
    end
    n_m1 = n_pts - 1'b1;
    mid  = n_pts >> 1;
  end

  logic [CMD_W-1:0] cmd_q;
  logic [IDX_W-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      cmd_q <= cmd_i;
      idx_q <= idx_i;
    end
  end

  // Read side: an entry outside the interior or never written reads as zero
  logic [MAX_POINTS-1:0] valid_q;
  logic [PT_W-1:0]       cnt_q, ra_q, rd_addr;
  logic                  rd_en, rd_keep, rkeep_q, rv_q;
  logic [DATA_W-1:0]     ram_rdata;

  always_comb begin
    if (ctrl_i.sweep_rd) begin
      rd_addr = cnt_q;
    end else if (cmd_q == CMD_READ) begin
      rd_addr = PT_W'(idx_q);
    end else begin
      rd_addr = mid[PT_W-1:0];
    end
  end

  assign rd_en   = ctrl_i.sweep_rd | ctrl_i.resp_rd;
  assign rd_keep = valid_q[rd_addr] && (rd_addr != '0) && (GP_W'(rd_addr) < n_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      rv_q <= ctrl_i.sweep_rd;
      if (ctrl_i.init) begin
        cnt_q <= PT_W'(1);
      end else if (ctrl_i.sweep_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sweep_rd) begin
      ra_q <= cnt_q;
    end
    if (rd_en) begin
      rkeep_q <= rd_keep;
    end
  end

  // Sliding window over old values; the arriving beat is the right neighbor
  logic signed [DATA_W-1:0] left_q, here_q, right;
  logic signed [LAP_W-1:0]  lap_d;

  assign right = rkeep_q ? $signed(ram_rdata) : '0;
  assign lap_d = LAP_W'(left_q) + LAP_W'(right) - (LAP_W'(here_q) <<< 1);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      left_q <= '0;
      here_q <= '0;
    end else if (rv_q) begin
      left_q <= here_q;
      here_q <= right;
    end
  end

  // Stage tokens
  logic s1_v, s2_v, s3_v, s4_v;
  logic [PT_W-1:0] s1_idx, s2_idx, s3_idx, s4_idx;
  logic signed [DATA_W-1:0] s1_here, s2_here, s3_here, s4_here;
  logic signed [LAP_W-1:0]  lap_q;
  logic [PPL_W-1:0]         pp_lo_q;
  logic signed [PPH_W-1:0]  pp_hi_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [TERM_W-1:0] term_q;
  logic signed [SAT_W-1:0]  sum;
  logic signed [DATA_W-1:0] new_q, chg;

  // The full product rebuilt from both halves; dropping the fraction floors it
  assign prod = (PROD_W'(pp_hi_q) <<< LO_W) + PROD_W'($signed({1'b0, pp_lo_q}));
  assign sum  = SAT_W'(s3_here) + SAT_W'(term_q)
              + SAT_W'($signed({1'b0, cfg_i.source_step}));
  assign chg  = sat32(SAT_W'(new_q) - SAT_W'(s4_here));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      // point 0 is a boundary: the first beat only fills the window
      s1_v <= rv_q && (ra_q > PT_W'(1));
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx  <= ra_q - 1'b1;
    s1_here <= here_q;
    lap_q   <= lap_d;

    s2_idx  <= s1_idx;
    s2_here <= s1_here;
    pp_lo_q <= PPL_W'(lap_q[LO_W-1:0]) * PPL_W'(cfg_i.coupling);
    pp_hi_q <= PPH_W'($signed(lap_q[LAP_W-1:LO_W])) * PPH_W'($signed({1'b0, cfg_i.coupling}));

    s3_idx  <= s2_idx;
    s3_here <= s2_here;
    term_q  <= prod[PROD_W-1:FRAC_W];

    s4_idx  <= s3_idx;
    s4_here <= s3_here;
    new_q   <= sat32(sum);
  end

  dss_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_POINTS)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (s4_v),
    .waddr_i(s4_idx),
    .wdata_i(new_q),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  logic signed [DATA_W-1:0] last_change_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      last_change_q <= '0;
    end else begin
      if (ctrl_i.clr_all) begin
        valid_q <= '0;
      end else begin
        // drop both boundaries and everything past the grid in use
        if (ctrl_i.trim) begin
          for (int i = 0; i < MAX_POINTS; i++) begin
            if (i == 0 || GP_W'(i) >= n_m1) begin
              valid_q[i] <= 1'b0;
            end
          end
        end
        if (s4_v) begin
          valid_q[s4_idx] <= 1'b1;
        end
      end
      if (s4_v && (GP_W'(s4_idx) == mid)) begin
        last_change_q <= chg;
      end
    end
  end

  // Result register
  logic                     out_valid_q, out_blocked, out_load, conv;
  logic signed [DATA_W-1:0] pv_q, mc_q;
  logic                     cv_q;

  assign out_blocked = out_valid_q && !out_o.ready;
  assign out_load    = ctrl_i.out_load && !out_blocked;
  assign conv        = (33'(last_change_q) <= 33'($signed({1'b0, cfg_i.tolerance})));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pv_q <= right;
      mc_q <= last_change_q;
      cv_q <= conv;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.point_value = pv_q;
  assign out_o.mid_change  = mc_q;
  assign out_o.converged   = cv_q;

  assign stat_o.cnt_last    = (GP_W'(cnt_q) == n_m1);
  assign stat_o.pipe_busy   = rv_q | s1_v | s2_v | s3_v | s4_v;
  assign stat_o.out_blocked = out_blocked;

endmodule

// ===== sv/diffusion_stencil_step_core.sv =====
`timescale 1ns / 1ps
// One-dimensional explicit heat-equation stepper on a grid of up to 64 signed
// Q8.24 points, cleared at reset, with both ends held at zero. Each input beat
// carries one command and yields exactly one result beat: advance updates every
// interior point from the old values, read returns one point, clear zeroes the
// grid, and status only reports. For an advance, the microprogram sweeps the grid one
// point per cycle through the single read port of the grid RAM, then drains the
// multiply-add pipeline. A new command is taken once the previous result sits in
// the output register. Registers are to be written only while no command is in
// flight; the block itself does not enforce this.
module diffusion_stencil_step_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dss_in_if.sink                         in_i,
  dss_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dss_pkg::*;

  cfg_t  cfg_q;
  ctrl_t ctrl;
  stat_t stat;
  logic  in_ready, in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_points <= RST_GRID_POINTS;
      cfg_q.coupling    <= RST_COUPLING;
      cfg_q.source_step <= RST_SOURCE_STEP;
      cfg_q.tolerance   <= RST_TOLERANCE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_POINTS: cfg_q.grid_points <= cfg_data_i[GP_W-1:0];
        CFG_COUPLING:    cfg_q.coupling    <= cfg_data_i[Q24_W-1:0];
        CFG_SOURCE_STEP: cfg_q.source_step <= cfg_data_i[Q24_W-1:0];
        CFG_TOLERANCE:   cfg_q.tolerance   <= cfg_data_i[Q24_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;

  dss_useq u_useq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .cmd_i     (in_i.cmd),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .in_ready_o(in_ready)
  );

  dss_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .ctrl_i   (ctrl),
    .in_fire_i(in_fire),
    .cmd_i    (in_i.cmd),
    .idx_i    (in_i.point_index),
    .stat_o   (stat),
    .out_o    (out_o)
  );

endmodule

// ===== sv/dss_checker.sv =====
`timescale 1ns / 1ps
`include "diffusion_stencil_step_core_assert.svh"
module dss_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [dss_pkg::DATA_W-1:0] point_value_i,
  input logic signed [dss_pkg::DATA_W-1:0] mid_change_i,
  input logic                             converged_i
);

  // one command in flight: the sink closes right after taking a beat
  `DSS_ASSERT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i, "input taken while busy")

  // a falling midpoint always counts as converged
  `DSS_ASSERT(a_neg_converged, clk_i, rst_ni, out_valid_i && mid_change_i[31] |-> converged_i, "negative change not converged")

  // hold a stalled result beat
  `DSS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(point_value_i) && $stable(mid_change_i), "stalled result changed")

  `DSS_ASSERT_ALWAYS(a_quiet_in_reset, clk_i, !rst_ni |-> !out_valid_i, "result shown during reset")

endmodule

bind diffusion_stencil_step_core dss_checker u_dss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .point_value_i(out_o.point_value),
  .mid_change_i (out_o.mid_change),
  .converged_i  (out_o.converged)
);

// ===== test/diffusion_stencil_step_core_tb.sv =====
`timescale 1ns / 1ps
module diffusion_stencil_step_core_tb;
  import dss_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 250;
  localparam int SETTLE_CYCLES  = 80;
  localparam int MAX_REPORTS    = 60;

  localparam logic signed [63:0] WIDE_TOP    = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] WIDE_BOTTOM = 64'shFFFF_FFFF_8000_0000;

  typedef struct {
    logic signed [DATA_W-1:0] point_value;
    logic signed [DATA_W-1:0] mid_change;
    logic                     converged;
  } grid_reply_t;

  class ftcs_tracker;
    logic signed [DATA_W-1:0] grid [MAX_POINTS];
    logic signed [DATA_W-1:0] last_change;
    logic [GP_W-1:0]          grid_points;
    logic [Q24_W-1:0]         coupling;
    logic [Q24_W-1:0]         source_step;
    logic [Q24_W-1:0]         tolerance;
    grid_reply_t              awaited_replies[$];
    int                       mismatches;

    function new();
      foreach (grid[i]) grid[i] = '0;
      last_change = '0;
      grid_points = RST_GRID_POINTS;
      coupling    = RST_COUPLING;
      source_step = RST_SOURCE_STEP;
      tolerance   = RST_TOLERANCE;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRID_POINTS: grid_points = data[GP_W-1:0];
        CFG_COUPLING:    coupling = data;
        CFG_SOURCE_STEP: source_step = data;
        CFG_TOLERANCE:   tolerance = data;
        default: ;
      endcase
    endfunction

    function int unsigned span();
      int unsigned n;
      n = grid_points;
      if (n < MIN_POINTS) n = MIN_POINTS;
      if (n > MAX_POINTS) n = MAX_POINTS;
      return n;
    endfunction

    // Ends of the grid in use read as zero.
    function logic signed [DATA_W-1:0] point(int unsigned i, int unsigned n);
      if (i == 0 || i >= n - 1) return '0;
      return grid[i];
    endfunction

    function logic signed [DATA_W-1:0] clip(logic signed [63:0] v);
      if (v > WIDE_TOP) return WIDE_TOP[DATA_W-1:0];
      if (v < WIDE_BOTTOM) return WIDE_BOTTOM[DATA_W-1:0];
      return v[DATA_W-1:0];
    endfunction

    function void advance(int unsigned n);
      logic signed [DATA_W-1:0] fresh [MAX_POINTS];
      logic signed [63:0]       left, here, right, lap, term, old_mid;
      int unsigned              mid, i;
      mid = n / 2;
      old_mid = point(mid, n);
      for (i = 0; i < MAX_POINTS; i++) begin
        if (i == 0 || i >= n - 1) begin
          fresh[i] = '0;
        end else begin
          left  = point(i - 1, n);
          here  = point(i, n);
          right = point(i + 1, n);
          lap   = left - 2 * here + right;
          // arithmetic shift of the exact product rounds toward minus infinity
          term  = (lap * $signed({40'd0, coupling})) >>> FRAC_W;
          fresh[i] = clip(here + term + $signed({40'd0, source_step}));
        end
      end
      grid = fresh;
      here = point(mid, n);
      last_change = clip(here - old_mid);
    endfunction

    function void note_command(logic [CMD_W-1:0] op, logic [IDX_W-1:0] idx);
      grid_reply_t        r;
      int unsigned        n;
      logic signed [63:0] change_wide, tol_wide;
      n = span();
      if (op == CMD_ADVANCE) begin
        advance(n);
      end else if (op == CMD_CLEAR) begin
        foreach (grid[i]) grid[i] = '0;
      end
      r.point_value = (op == CMD_READ) ? point(idx, n) : point(n / 2, n);
      r.mid_change  = last_change;
      change_wide   = last_change;
      tol_wide      = $signed({40'd0, tolerance});
      r.converged   = (change_wide <= tol_wide);
      awaited_replies.push_back(r);
    endfunction

    function void flag(string field, logic signed [63:0] want, logic signed [63:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_reply(logic signed [DATA_W-1:0] pv, logic signed [DATA_W-1:0] mc,
                              logic conv);
      grid_reply_t want;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result beat with none expected, point_value %0d mid_change %0d",
                   $time, pv, mc);
        return;
      end
      want = awaited_replies.pop_front();
      if (want.point_value !== pv) flag("point_value", want.point_value, pv);
      if (want.mid_change !== mc) flag("mid_change", want.mid_change, mc);
      if (want.converged !== conv) flag("converged", want.converged, conv);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dss_in_if  cmd_if ();
  dss_out_if reply_if ();

  ftcs_tracker tracker = new();

  bit tx_idle     = 1'b1;
  bit rx_idle     = 1'b1;
  bit rx_hold_req = 1'b0;
  int quiet_cycles = 0;

  diffusion_stencil_step_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (cmd_if),
    .out_o      (reply_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Track both channels and bound the time without any beat.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (reply_if.valid && reply_if.ready)
        tracker.check_reply(reply_if.point_value, reply_if.mid_change, reply_if.converged);
      if (cmd_if.valid && cmd_if.ready)
        tracker.note_command(cmd_if.cmd, cmd_if.point_index);
      if ((reply_if.valid && reply_if.ready) || (cmd_if.valid && cmd_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("diffusion_stencil_step_core regression: fail");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold on request.
  initial begin
    int gap;
    reply_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        reply_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      gap = rx_idle ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        reply_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      reply_if.ready <= 1'b1;
      do @(posedge clk_i); while (!reply_if.valid);
    end
  end

  task automatic send_item(logic [CMD_W-1:0] op, logic [IDX_W-1:0] idx);
    int gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.cmd         <= op;
    cmd_if.point_index <= idx;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  // Drop valid and hold until every expected result beat has come back.
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.awaited_replies.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_reg(idx, data);
  endtask

  task automatic set_regs(logic [GP_W-1:0] gp, logic [Q24_W-1:0] cp,
                          logic [Q24_W-1:0] src, logic [Q24_W-1:0] tol);
    write_reg(CFG_GRID_POINTS, CFG_DATA_W'(gp));
    write_reg(CFG_COUPLING, cp);
    write_reg(CFG_SOURCE_STEP, src);
    write_reg(CFG_TOLERANCE, tol);
  endtask

  task automatic pick_random_regs();
    logic [GP_W-1:0]  gp;
    logic [Q24_W-1:0] cp, src, tol;
    // mostly small grids keep each advance short
    case ($urandom_range(0, 9))
      0:       gp = GP_W'($urandom_range(0, 2));
      1:       gp = GP_W'($urandom_range(65, 127));
      2:       gp = GP_W'(MAX_POINTS);
      default: gp = GP_W'($urandom_range(3, 16));
    endcase
    if ($urandom_range(0, 5) == 0) begin
      cp = Q24_W'($urandom_range(8388609, 16777215));
    end else begin
      cp = Q24_W'($urandom_range(0, 8388608));
    end
    case ($urandom_range(0, 2))
      0:       src = '0;
      1:       src = Q24_W'($urandom_range(0, 65535));
      default: src = Q24_W'($urandom);
    endcase
    if ($urandom_range(0, 1) == 0) begin
      tol = Q24_W'($urandom_range(0, 4096));
    end else begin
      tol = Q24_W'($urandom);
    end
    set_regs(gp, cp, src, tol);
  endtask

  task automatic send_random_item(int advance_weight);
    logic [CMD_W-1:0] op;
    logic [IDX_W-1:0] idx;
    int               pick;
    pick = $urandom_range(0, 99);
    if (pick < advance_weight) begin
      op = CMD_ADVANCE;
    end else if (pick < advance_weight + 6) begin
      op = CMD_CLEAR;
    end else if (pick < advance_weight + 16) begin
      op = CMD_STATUS;
    end else begin
      op = CMD_READ;
    end
    if ($urandom_range(0, 3) == 0) begin
      idx = IDX_W'($urandom_range(0, 63));
    end else begin
      idx = IDX_W'($urandom_range(0, tracker.span() - 1));
    end
    send_item(op, idx);
  endtask

  task automatic run_phase(int items, int advance_weight, bit hold);
    int k;
    tx_idle = ($urandom_range(0, 3) != 0);
    rx_idle = ($urandom_range(0, 3) != 0);
    if (hold) begin
      // keep offering while the result side stalls, so the input backs up
      tx_idle = 1'b0;
      rx_hold_req = 1'b1;
    end
    for (k = 0; k < items; k++) begin
      if (k == items / 2) wait_drained();
      send_random_item(advance_weight);
    end
    wait_drained();
  endtask

  initial begin
    int k;
    int p;
    cmd_if.valid       <= 1'b0;
    cmd_if.cmd         <= CMD_STATUS;
    cmd_if.point_index <= '0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_GRID_POINTS;
    cfg_data_i         <= '0;
    rst_ni             <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: full grid, steps, reads at both ends and edges, clear.
    send_item(CMD_ADVANCE, 6'd0);
    send_item(CMD_ADVANCE, 6'd63);
    send_item(CMD_ADVANCE, 6'd21);
    send_item(CMD_READ, 6'd0);
    send_item(CMD_READ, 6'd1);
    send_item(CMD_READ, 6'd32);
    send_item(CMD_READ, 6'd62);
    send_item(CMD_READ, 6'd63);
    send_item(CMD_STATUS, 6'd42);
    send_item(CMD_CLEAR, 6'd63);
    send_item(CMD_STATUS, 6'd0);
    send_item(CMD_ADVANCE, 6'd0);
    wait_drained();

    // Unstable coupling on a tiny grid: values swing and saturate both ways.
    set_regs(7'd5, 24'hFF_FFFF, 24'hFF_FFFF, 24'h0);
    for (k = 0; k < 10; k++) send_item(CMD_ADVANCE, 6'($urandom_range(0, 63)));
    send_item(CMD_READ, 6'd2);
    send_item(CMD_READ, 6'd4);
    wait_drained();

    // Register extremes, then random settings.
    set_regs(7'd0, 24'h0, 24'h0, 24'h0);
    run_phase(20, 40, 1'b0);
    set_regs(7'd127, 24'h80_0000, 24'hFF_FFFF, 24'hFF_FFFF);
    run_phase(30, 50, 1'b0);
    set_regs(7'd7, 24'h40_0000, 24'h00_0100, 24'h0);
    run_phase(30, 45, 1'b1);
    for (p = 0; p < 10; p++) begin
      pick_random_regs();
      run_phase(32, $urandom_range(25, 60), 1'b0);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.awaited_replies.size() == 0) begin
      $display("diffusion_stencil_step_core regression: pass");
    end else begin
      $display("diffusion_stencil_step_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/dss_pkg.sv
sv/dss_in_if.sv
sv/dss_out_if.sv
sv/dss_ram.sv
sv/dss_useq.sv
sv/dss_datapath.sv
sv/diffusion_stencil_step_core.sv
sv/dss_checker.sv
test/diffusion_stencil_step_core_tb.sv
